// File: design/mmcrc_pkg.sv
// mmcrc_pkg: algorithm codes, register indexes, widths and crc helper functions
// for the multi-mode crc engine; no dependencies, compiled first
package mmcrc_pkg;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned CRC_W      = 32;
	localparam int unsigned ALG_W      = 3;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 3;

	typedef enum logic [ALG_W-1:0] {
		ALG_CRC8   = 3'd0,
		ALG_CRC16  = 3'd1,
		ALG_CCITT  = 3'd2,
		ALG_KERMIT = 3'd3,
		ALG_CRC32  = 3'd4
	} alg_t;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ALGORITHM  = 1'd0;
	localparam cfg_idx_t REG_BIG_ENDIAN = 1'd1;

	localparam logic [7:0]       POLY8      = 8'hD5;
	localparam logic [15:0]      POLY_CCITT = 16'h1021;
	localparam logic [CRC_W-1:0] POLY16     = 32'h0000_A001;
	localparam logic [CRC_W-1:0] POLY_KERM  = 32'h0000_8408;
	localparam logic [CRC_W-1:0] POLY32     = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC32_INIT = 32'hFFFF_FFFF;
	localparam logic [7:0]       CRC8_XOR   = 8'hFF;

	// init value of the selected algorithm, spare codes behave as crc-32
	function automatic logic [CRC_W-1:0] init_value(logic [ALG_W-1:0] alg);
		logic [CRC_W-1:0] v;
		v = (alg <= ALG_KERMIT) ? '0 : CRC32_INIT;
		return v;
	endfunction

	function automatic logic [15:0] swap16(logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [CRC_W-1:0] swap32(logic [CRC_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// output xor, width masking and optional byte swap
	function automatic logic [CRC_W-1:0] finalize(logic [ALG_W-1:0] alg, logic big_endian,
			logic [CRC_W-1:0] crc);
		logic [CRC_W-1:0] r;
		logic [15:0]      h;
		h = crc[15:0];
		unique case (alg)
			ALG_CRC8: begin
				r = {24'd0, crc[7:0] ^ CRC8_XOR};
			end
			ALG_CRC16, ALG_CCITT, ALG_KERMIT: begin
				r = {16'd0, big_endian ? h : swap16(h)};
			end
			default: begin
				r = big_endian ? ~crc : swap32(~crc);
			end
		endcase
		return r;
	endfunction

endpackage

// File: design/mmcrc_if.sv
// mmcrc_if: valid/ready channel interfaces for the message byte and checksum streams
// depends on mmcrc_pkg for widths
interface mmcrc_msg_if;
	logic                             valid;
	logic                             ready;
	logic [mmcrc_pkg::DATA_W-1:0]     data_byte;
	logic                             restart;
	logic                             last_byte;

	modport source(output valid, output data_byte, output restart, output last_byte,
		input ready);
	modport sink(input valid, input data_byte, input restart, input last_byte,
		output ready);
endinterface

interface mmcrc_sum_if;
	logic                             valid;
	logic                             ready;
	logic [mmcrc_pkg::CRC_W-1:0]      checksum;

	modport source(output valid, output checksum, input ready);
	modport sink(input valid, input checksum, output ready);
endinterface

// File: design/mmcrc_fold.sv
// mmcrc_fold: folds one message byte into the running crc for the selected algorithm
// depends on mmcrc_pkg
module mmcrc_fold (
	input  logic [mmcrc_pkg::ALG_W-1:0]  alg,
	input  logic [mmcrc_pkg::CRC_W-1:0]  crc,
	input  logic [mmcrc_pkg::DATA_W-1:0] data_byte,
	output logic [mmcrc_pkg::CRC_W-1:0]  crc_next
);

	logic [7:0]                     c8;
	logic [15:0]                    c16;
	logic [mmcrc_pkg::CRC_W-1:0]    cr;
	logic [mmcrc_pkg::CRC_W-1:0]    poly;

	// msb-first crc-8
	always_comb begin
		c8 = crc[7:0] ^ data_byte;
		for (int k = 0; k < 8; k++) begin
			c8 = {c8[6:0], 1'b0} ^ (c8[7] ? mmcrc_pkg::POLY8 : 8'd0);
		end
	end

	// msb-first ccitt
	always_comb begin
		c16 = crc[15:0] ^ {data_byte, 8'd0};
		for (int k = 0; k < 8; k++) begin
			c16 = {c16[14:0], 1'b0} ^ (c16[15] ? mmcrc_pkg::POLY_CCITT : 16'd0);
		end
	end

	// reflected algorithms share one shift chain
	always_comb begin
		unique case (alg)
			mmcrc_pkg::ALG_CRC16: begin
				poly = mmcrc_pkg::POLY16;
				cr   = {16'd0, crc[15:0]};
			end
			mmcrc_pkg::ALG_KERMIT: begin
				poly = mmcrc_pkg::POLY_KERM;
				cr   = {16'd0, crc[15:0]};
			end
			default: begin
				poly = mmcrc_pkg::POLY32;
				cr   = crc;
			end
		endcase
		cr = cr ^ {24'd0, data_byte};
		for (int k = 0; k < 8; k++) begin
			cr = {1'b0, cr[31:1]} ^ (cr[0] ? poly : '0);
		end
	end

	always_comb begin
		unique case (alg)
			mmcrc_pkg::ALG_CRC8: begin
				crc_next = {24'd0, c8};
			end
			mmcrc_pkg::ALG_CCITT: begin
				crc_next = {16'd0, c16};
			end
			mmcrc_pkg::ALG_CRC16, mmcrc_pkg::ALG_KERMIT: begin
				crc_next = {16'd0, cr[15:0]};
			end
			default: begin
				crc_next = cr;
			end
		endcase
	end

endmodule

// File: design/multi_mode_crc_engine.sv
// multi_mode_crc_engine: top level of the byte-wise crc-8/crc-16/ccitt/kermit/crc-32 engine
// depends on mmcrc_pkg, mmcrc_if and mmcrc_fold
//
// usage
//   msg channel: one transaction per message byte, with restart (reload the init value
//   before this byte) and last_byte (emit the checksum after this byte)
//   sum channel: one transaction per last_byte, carrying the finished checksum
//   config port: cfg_we/cfg_index/cfg_data, index 0 algorithm, index 1 big_endian;
//   writing the algorithm reloads the running crc with its init value
// timing
//   one byte per cycle sustained unless msg.ready drops (see stalls); a taken byte is
//   registered into the fold stage, and the checksum is registered when the last byte leaves it
//   the running crc lives in a one-word synchronous ram read every cycle; the word
//   written on the previous edge is forwarded past the ram's read register
// reset
//   algorithm crc-32, big-endian on, running crc at the crc-32 init value, no result
//   pending; no clearing pass is needed
// stalls
//   the checksum waits in the output register; bytes keep flowing while it waits, and
//   msg.ready drops only when a second last byte reaches the fold stage
module multi_mode_crc_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mmcrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmcrc_pkg::CFG_DATA_W-1:0]    cfg_data,
	mmcrc_msg_if.sink                           msg,
	mmcrc_sum_if.source                         sum
);

	logic [mmcrc_pkg::ALG_W-1:0]  algorithm_q;
	logic                         big_endian_q;
	logic                         alg_wr;

	logic                         valid_s1;
	logic [mmcrc_pkg::DATA_W-1:0] byte_s1;
	logic                         restart_s1;
	logic                         last_s1;

	logic [mmcrc_pkg::CRC_W-1:0]  crc_mem [1];
	logic [mmcrc_pkg::CRC_W-1:0]  rd_q;
	logic [mmcrc_pkg::CRC_W-1:0]  wr_data_q;
	logic                         fwd_q;
	logic                         crc_valid_q;

	logic [mmcrc_pkg::CRC_W-1:0]  crc_cur;
	logic [mmcrc_pkg::CRC_W-1:0]  crc_base;
	logic [mmcrc_pkg::CRC_W-1:0]  crc_next;

	logic                         out_valid_q;
	logic [mmcrc_pkg::CRC_W-1:0]  checksum_q;

	logic                         out_free;
	logic                         adv_s1;
	logic                         msg_acc;

	assign alg_wr   = cfg_we && (cfg_index == mmcrc_pkg::REG_ALGORITHM);
	assign out_free = !out_valid_q || sum.ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign msg.ready = !valid_s1 || adv_s1;
	assign msg_acc  = msg.valid && msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			algorithm_q  <= mmcrc_pkg::ALG_CRC32;
			big_endian_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmcrc_pkg::REG_ALGORITHM:  algorithm_q  <= cfg_data;
				mmcrc_pkg::REG_BIG_ENDIAN: big_endian_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// fold stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_acc) begin
			byte_s1    <= msg.data_byte;
			restart_s1 <= msg.restart;
			last_s1    <= msg.last_byte;
		end
	end

	// running crc ram, read every cycle
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			crc_mem[0] <= crc_next;
		end
		rd_q      <= crc_mem[0];
		wr_data_q <= crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q       <= 1'b0;
			crc_valid_q <= 1'b0;
		end else if (alg_wr) begin
			fwd_q       <= 1'b0;
			crc_valid_q <= 1'b0;
		end else begin
			fwd_q <= adv_s1;
			if (adv_s1) begin
				crc_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		priority if (!crc_valid_q) begin
			crc_cur = mmcrc_pkg::init_value(algorithm_q);
		end else if (fwd_q) begin
			crc_cur = wr_data_q;
		end else begin
			crc_cur = rd_q;
		end
		crc_base = restart_s1 ? mmcrc_pkg::init_value(algorithm_q) : crc_cur;
	end

	mmcrc_fold u_fold (
		.alg       (algorithm_q),
		.crc       (crc_base),
		.data_byte (byte_s1),
		.crc_next  (crc_next)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (sum.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			checksum_q <= mmcrc_pkg::finalize(algorithm_q, big_endian_q, crc_next);
		end
	end

	assign sum.valid    = out_valid_q;
	assign sum.checksum = checksum_q;

endmodule

// File: design/mmcrc_check.sv
// mmcrc_check: port-level assertions for the multi-mode crc engine, bound to the top level
// depends on multi_mode_crc_engine and the channel interfaces
module mmcrc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_last,
	input logic        sum_valid,
	input logic        sum_ready,
	input logic [31:0] sum_checksum
);

	// held result stays offered
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum_ready |=> sum_valid)
		else $error("checksum withdrawn before transaction");

	a_sum_stable: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum_ready |=> $stable(sum_checksum))
		else $error("checksum changed while stalled");

	// back-pressure only comes from a stalled receiver
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_ready |-> sum_valid && !sum_ready)
		else $error("msg stalled without a stalled checksum");

	// a last byte always leads to a result on offer once it has passed the fold stage and output register
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_last |-> ##2 sum_valid)
		else $error("no checksum after last byte");

endmodule

bind multi_mode_crc_engine mmcrc_check u_mmcrc_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.msg_valid    (msg.valid),
	.msg_ready    (msg.ready),
	.msg_last     (msg.last_byte),
	.sum_valid    (sum.valid),
	.sum_ready    (sum.ready),
	.sum_checksum (sum.checksum)
);

// File: tb/multi_mode_crc_engine_test.sv
`timescale 1ns / 1ps
// multi_mode_crc_engine_test: self-checking bench for the byte-wise multi-mode crc engine,
// predicting each checksum from the byte stream and register writes
// depends on mmcrc_pkg, mmcrc_if and the multi_mode_crc_engine rtl

class crc_predictor;
	logic [mmcrc_pkg::ALG_W-1:0] sel_alg;
	bit                          big_end;
	logic [mmcrc_pkg::CRC_W-1:0] crc_acc;
	logic [mmcrc_pkg::CRC_W-1:0] awaited_checksums[$];
	int                          errors;

	function new();
		sel_alg = mmcrc_pkg::ALG_CRC32;
		big_end = 1'b1;
		crc_acc = seed(sel_alg);
		errors  = 0;
	endfunction

	function logic [mmcrc_pkg::CRC_W-1:0] seed(logic [mmcrc_pkg::ALG_W-1:0] a);
		return (a <= mmcrc_pkg::ALG_KERMIT) ? '0 : '1;
	endfunction

	function logic [mmcrc_pkg::CRC_W-1:0] fold_lsb_first(logic [mmcrc_pkg::CRC_W-1:0] acc,
			logic [7:0] b, logic [mmcrc_pkg::CRC_W-1:0] poly);
		logic [mmcrc_pkg::CRC_W-1:0] c;
		c = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = (c >> 1) ^ (c[0] ? poly : '0);
		return c;
	endfunction

	function void set_reg(mmcrc_pkg::cfg_idx_t idx, logic [mmcrc_pkg::CFG_DATA_W-1:0] value);
		if (idx == mmcrc_pkg::REG_ALGORITHM) begin
			sel_alg = value;
			crc_acc = seed(value);
		end else if (idx == mmcrc_pkg::REG_BIG_ENDIAN) begin
			big_end = value[0];
		end
	endfunction

	function void take_byte(logic [7:0] b, bit restart, bit last);
		logic [7:0]                  c8;
		logic [15:0]                 c16;
		logic [mmcrc_pkg::CRC_W-1:0] sum;
		if (restart)
			crc_acc = seed(sel_alg);
		unique case (sel_alg)
			mmcrc_pkg::ALG_CRC8: begin
				c8 = crc_acc[7:0] ^ b;
				for (int k = 0; k < 8; k++)
					c8 = {c8[6:0], 1'b0} ^ (c8[7] ? mmcrc_pkg::POLY8 : 8'h00);
				crc_acc = {24'd0, c8};
				sum = {24'd0, c8 ^ mmcrc_pkg::CRC8_XOR};
			end
			mmcrc_pkg::ALG_CRC16, mmcrc_pkg::ALG_KERMIT: begin
				crc_acc = fold_lsb_first({16'd0, crc_acc[15:0]}, b,
					(sel_alg == mmcrc_pkg::ALG_CRC16) ? mmcrc_pkg::POLY16 :
					mmcrc_pkg::POLY_KERM) & 32'h0000_FFFF;
				c16 = crc_acc[15:0];
				sum = {16'd0, big_end ? c16 : {c16[7:0], c16[15:8]}};
			end
			mmcrc_pkg::ALG_CCITT: begin
				c16 = crc_acc[15:0] ^ {b, 8'd0};
				for (int k = 0; k < 8; k++)
					c16 = {c16[14:0], 1'b0} ^
						(c16[15] ? mmcrc_pkg::POLY_CCITT : 16'h0000);
				crc_acc = {16'd0, c16};
				sum = {16'd0, big_end ? c16 : {c16[7:0], c16[15:8]}};
			end
			default: begin
				crc_acc = fold_lsb_first(crc_acc, b, mmcrc_pkg::POLY32);
				sum = ~crc_acc;
				if (!big_end)
					sum = {sum[7:0], sum[15:8], sum[23:16], sum[31:24]};
			end
		endcase
		if (last)
			awaited_checksums.push_back(sum);
	endfunction

	function void check_checksum(logic [mmcrc_pkg::CRC_W-1:0] got);
		logic [mmcrc_pkg::CRC_W-1:0] want;
		if (awaited_checksums.size() == 0) begin
			$display("%0t: unexpected checksum, expected none, actual %08h", $time, got);
			errors++;
		end else begin
			want = awaited_checksums.pop_front();
			if (want !== got) begin
				$display("%0t: checksum mismatch, expected %08h, actual %08h",
					$time, want, got);
				errors++;
			end
		end
	endfunction
endclass

module multi_mode_crc_engine_test;

	localparam logic [mmcrc_pkg::ALG_W-1:0] ALG_SPARE_LO = 3'd5;
	localparam logic [mmcrc_pkg::ALG_W-1:0] ALG_SPARE_HI = 3'd7;
	localparam int RANDOM_BYTES = 550;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 300000;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	mmcrc_pkg::cfg_idx_t              cfg_index;
	logic [mmcrc_pkg::CFG_DATA_W-1:0] cfg_data;

	mmcrc_msg_if msg_ch();
	mmcrc_sum_if sum_ch();

	crc_predictor predictor;
	bit           no_idle;
	int           bytes_sent;
	int           sums_seen;
	int           stall_left;
	bit           long_hold_done;
	int unsigned  cycles;

	multi_mode_crc_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.msg(msg_ch),
		.sum(sum_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_mode_crc_engine_test failed");
			$finish;
		end
	end

	// checksum receiver, with random back-pressure and one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (sum_ch.valid && sum_ch.ready) begin
				predictor.check_checksum(sum_ch.checksum);
				sums_seen++;
			end
			if (stall_left != 0) begin
				stall_left--;
				sum_ch.ready <= 1'b0;
			end else if (!long_hold_done && sums_seen >= 20) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				sum_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				sum_ch.ready <= 1'b0;
			end else begin
				sum_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit restart, input bit last);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.data_byte <= b;
		msg_ch.restart   <= restart;
		msg_ch.last_byte <= last;
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
		predictor.take_byte(b, restart, last);
		bytes_sent++;
	endtask

	// drain outstanding checksums and let the fold stage empty
	task automatic settle();
		msg_ch.valid <= 1'b0;
		while (predictor.awaited_checksums.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input mmcrc_pkg::cfg_idx_t idx,
			input logic [mmcrc_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		predictor.set_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_message();
		int         len;
		int         pick;
		bit         noisy;
		logic [7:0] b;
		noisy = ($urandom_range(0, 9) == 0);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 7);
			b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
			if (noisy)
				send_byte(b, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
			else
				send_byte(b, i == 0, i == len - 1);
		end
	endtask

	initial begin
		predictor        = new();
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		msg_ch.valid     = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.restart   = 1'b0;
		msg_ch.last_byte = 1'b0;
		sum_ch.ready     = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// crc-32 state straight out of reset, no restart
		send_byte(8'h31, 1'b0, 1'b1);
		settle();
		// algorithm write reloads the register, so no restart here
		write_reg(mmcrc_pkg::REG_ALGORITHM, mmcrc_pkg::ALG_CRC8);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b1);
		settle();
		write_reg(mmcrc_pkg::REG_BIG_ENDIAN, 3'd0);
		write_reg(mmcrc_pkg::REG_ALGORITHM, mmcrc_pkg::ALG_CRC16);
		send_byte(8'h01, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		settle();
		write_reg(mmcrc_pkg::REG_ALGORITHM, mmcrc_pkg::ALG_CCITT);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h7E, 1'b0, 1'b1);
		settle();
		write_reg(mmcrc_pkg::REG_ALGORITHM, mmcrc_pkg::ALG_KERMIT);
		write_reg(mmcrc_pkg::REG_BIG_ENDIAN, 3'd1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hA5, 1'b0, 1'b1);
		// carries on from the previous checksum
		send_byte(8'h5A, 1'b0, 1'b1);
		settle();
		write_reg(mmcrc_pkg::REG_ALGORITHM, mmcrc_pkg::ALG_CRC32);
		write_reg(mmcrc_pkg::REG_BIG_ENDIAN, 3'd0);
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h12, 1'b0, 1'b0);
		// endianness flip mid-message keeps the running crc
		settle();
		write_reg(mmcrc_pkg::REG_BIG_ENDIAN, 3'd1);
		send_byte(8'h34, 1'b0, 1'b1);
		settle();
		write_reg(mmcrc_pkg::REG_ALGORITHM, ALG_SPARE_HI);
		send_byte(8'h55, 1'b1, 1'b0);
		send_byte(8'hAA, 1'b0, 1'b1);
		settle();
		write_reg(mmcrc_pkg::REG_ALGORITHM, ALG_SPARE_LO);
		write_reg(mmcrc_pkg::REG_BIG_ENDIAN, 3'd0);
		send_byte(8'h01, 1'b1, 1'b1);

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			no_idle = (bytes_sent > RANDOM_BYTES * 4 / 5);
			settle();
			if ($urandom_range(0, 3) != 0)
				write_reg(mmcrc_pkg::REG_ALGORITHM,
					3'($urandom_range(mmcrc_pkg::ALG_CRC8, ALG_SPARE_HI)));
			if ($urandom_range(0, 1) == 0)
				write_reg(mmcrc_pkg::REG_BIG_ENDIAN, 3'($urandom_range(0, 1)));
			repeat ($urandom_range(2, 8)) send_random_message();
		end
		settle();
		repeat (10) @(posedge clk);

		if (predictor.errors == 0 && predictor.awaited_checksums.size() == 0)
			$display("multi_mode_crc_engine_test passed");
		else
			$display("multi_mode_crc_engine_test failed");
		$finish;
	end

endmodule

// File: sim.f
design/mmcrc_pkg.sv
design/mmcrc_if.sv
design/mmcrc_fold.sv
design/multi_mode_crc_engine.sv
design/mmcrc_check.sv
tb/multi_mode_crc_engine_test.sv
